// ===== src/pias_pkg.sv =====
// Package for the area hit test: shape codes, config indexes, widths.
// No dependencies.
package pias_pkg;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 23;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SHAPE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLEN   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SWID   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAN    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HTOL   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PSIZE  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ETOL   = 3'd7;

    localparam logic [2:0] SHAPE_CIRCLE = 3'd0;
    localparam logic [2:0] SHAPE_CONE   = 3'd1;
    localparam logic [2:0] SHAPE_STRIP  = 3'd2;
    localparam logic [2:0] SHAPE_SQUARE = 3'd3;
    localparam logic [2:0] SHAPE_POLY   = 3'd4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic [2:0]  shape;
        logic [14:0] radius;
        logic [14:0] slen;
        logic [14:0] swid;
        logic [22:0] tan_half;
        logic [11:0] htol;
        logic [5:0]  psize;
        logic [7:0]  etol;
    } t_cfg;
endpackage

// ===== src/pias_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface pias_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/pias_vmem.sv =====
// Vertex memory: one write port, one read port, registered read.
// Depends on nothing.
module pias_vmem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);
    logic [31:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/point_in_area_shape_test.sv =====
// Top level of the area hit test: sequencer, rotation, shape tests, polygon walk.
// Depends on pias_pkg, pias_if and pias_vmem.
//
// channel | dir | payload
// in_ch   | in  | action, vertex_slot, point/center xyz, yaw cos/sin
// out_ch  | out | inside_res
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// A vertex write goes to the vertex memory on its transfer. A query holds the
// block from its transfer to its result transfer, through rotate, round, square,
// shape test and output; a polygon query also reads the closing vertex and walks
// each edge (read, data, products, compare), ending early on an edge hit.
// Sync reset clears the sequencer, output valid and config, not the datapath or
// memory. A stalled result holds in the output register and blocks input.
module point_in_area_shape_test
    import pias_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int COORD_BITS   = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    pias_if.sink                     in_ch,
    pias_if.source                   out_ch
);
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CB = COORD_BITS;
    localparam int DB = CB + 1;
    localparam int PB = DB + 17;
    localparam int LB = 30;

    localparam logic [3:0] S_IDLE = 4'd0, S_ROT = 4'd1, S_RND = 4'd2, S_SQ = 4'd3,
        S_SHAPE = 4'd4, S_RD = 4'd5, S_E1 = 4'd6, S_E2 = 4'd7, S_E3 = 4'd8,
        S_OUT = 4'd9;

    t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{shape: SHAPE_CIRCLE, radius: 15'd16, slen: 15'd16,
                swid: 15'd16, tan_half: 23'd65536, htol: 12'd16, psize: 6'd3,
                etol: 8'd3};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHAPE:  r_cfg.shape    <= i_cfg_data[2:0];
                CFG_RADIUS: r_cfg.radius   <= i_cfg_data[14:0];
                CFG_SLEN:   r_cfg.slen     <= i_cfg_data[14:0];
                CFG_SWID:   r_cfg.swid     <= i_cfg_data[14:0];
                CFG_TAN:    r_cfg.tan_half <= i_cfg_data[22:0];
                CFG_HTOL:   r_cfg.htol     <= i_cfg_data[11:0];
                CFG_PSIZE:  r_cfg.psize    <= i_cfg_data[5:0];
                CFG_ETOL:   r_cfg.etol     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic              in_act;
    logic [4:0]        in_slot;
    logic signed [CB-1:0] in_px, in_py, in_pz, in_cx, in_cy, in_cz;
    logic signed [15:0] in_c, in_s;
    assign {in_act, in_slot, in_px, in_py, in_pz, in_cx, in_cy, in_cz, in_c, in_s} =
        in_ch.data;

    logic [3:0] r_st;
    logic       r_res;
    logic       r_ovld;
    assign in_ch.ready   = (r_st == S_IDLE) && !r_ovld;
    assign out_ch.valid  = r_ovld;
    assign out_ch.data   = r_res;
    wire   acc = in_ch.valid && in_ch.ready;

    // vertex memory
    logic          vm_we;
    logic [AW-1:0] vm_raddr;
    logic [31:0]   vm_rdata;
    assign vm_we = acc && (in_act == ACT_WRITE) && ({27'd0, in_slot} < 32'(MAX_VERTICES));
    pias_vmem #(.DEPTH(MAX_VERTICES), .AW(AW)) u_vmem (
        .i_clk(i_clk), .i_we(vm_we), .i_waddr(AW'(in_slot)),
        .i_wdata({in_py[15:0], in_px[15:0]}), .i_raddr(vm_raddr), .o_rdata(vm_rdata));

    // datapath registers
    logic signed [DB-1:0] r_dx, r_dy;
    logic                 r_hok;
    logic signed [15:0]   r_c, r_s;
    logic signed [PB-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [LB-1:0] r_lx, r_ly;
    logic [61:0]          r_sq;
    logic [29:0]          r_rr;
    logic signed [55:0]   r_ct;
    logic                 r_inside;
    logic [6:0]           r_cnt;
    logic [6:0]           r_n;
    logic signed [16:0]   r_ax, r_ay, r_bx, r_by;
    logic signed [61:0]   r_m0, r_m1, r_m2, r_m3, r_m4, r_m5;
    logic                 r_first;

    // rounding of rotated values
    function automatic logic signed [LB-1:0] rnd(input logic signed [PB:0] v);
        logic signed [PB:0] t;
        logic signed [PB:0] q;
        t = v + (PB+1)'(8192);
        q = t >>> 14;
        if (q > (PB+1)'(1 << 28)) return LB'(1 << 28);
        if (q < -(PB+1)'(1 << 28)) return -LB'(1 << 28);
        return LB'(q);
    endfunction

    logic signed [LB-1:0] alx, aly;
    assign alx = r_lx[LB-1] ? -r_lx : r_lx;
    assign aly = r_ly[LB-1] ? -r_ly : r_ly;

    // edge arithmetic
    logic signed [LB:0] pax, pay, pbx, pby;
    logic signed [17:0] ebx, eby;
    assign pax = r_lx - LB'(r_ax);
    assign pay = r_ly - LB'(r_ay);
    assign pbx = r_lx - LB'(r_bx);
    assign pby = r_ly - LB'(r_by);
    assign ebx = r_bx - r_ax;
    assign eby = r_by - r_ay;
    logic signed [62:0] cross_v, dot_v, etol_s;
    assign cross_v = 63'(r_m0) - 63'(r_m1);
    assign dot_v   = 63'(r_m2) + 63'(r_m3);
    assign etol_s  = $signed(63'(r_cfg.etol));
    logic on_e, straddle, crs;
    assign on_e = (cross_v <= etol_s) && (cross_v >= -etol_s) && (dot_v <= etol_s);
    assign straddle = (LB'(r_ay) > r_ly) != (LB'(r_by) > r_ly);
    assign crs = (eby > 0) ? (r_m4 < r_m5) : (r_m4 > r_m5);

    logic [6:0] nsat;
    assign nsat = (7'(r_cfg.psize) > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : 7'(r_cfg.psize);
    assign vm_raddr = (r_cnt == 7'd0) ? AW'(r_n - 7'd1) : AW'(r_cnt - 7'd1);

    logic signed [DB-1:0] dz;
    assign dz = DB'(in_pz) - DB'(in_cz);

    // saturated local coords fit in 30 bits; clamp to 17 bits for polygon math
    // is unsafe, so the polygon path uses 30-bit locals directly in products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_ovld <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) r_ovld <= 1'b0;
            case (r_st)
                S_IDLE: if (acc && in_act == ACT_QUERY) begin
                    r_dx  <= DB'(in_px) - DB'(in_cx);
                    r_dy  <= DB'(in_py) - DB'(in_cy);
                    r_hok <= (dz[DB-1] ? -dz : dz) <= DB'(r_cfg.htol);
                    r_c   <= in_c;
                    r_s   <= in_s;
                    r_st  <= S_ROT;
                end
                S_ROT: begin
                    r_p0 <= PB'(r_dx) * PB'(r_c);
                    r_p1 <= PB'(r_dy) * PB'(r_s);
                    r_p2 <= PB'(r_dy) * PB'(r_c);
                    r_p3 <= PB'(r_dx) * PB'(r_s);
                    r_st <= S_RND;
                end
                S_RND: begin
                    r_lx <= rnd((PB+1)'(r_p0) + (PB+1)'(r_p1));
                    r_ly <= rnd((PB+1)'(r_p2) - (PB+1)'(r_p3));
                    r_st <= S_SQ;
                end
                S_SQ: begin
                    r_sq <= 62'(alx) * 62'(alx) + 62'(aly) * 62'(aly);
                    r_rr <= 30'(r_cfg.radius) * 30'(r_cfg.radius);
                    r_ct <= 56'(r_lx) * 56'($signed({1'b0, r_cfg.tan_half}));
                    r_st <= S_SHAPE;
                end
                S_SHAPE: begin
                    r_st <= S_OUT;
                    case (r_cfg.shape)
                        SHAPE_CIRCLE: r_res <= r_hok && (r_sq <= 62'(r_rr));
                        SHAPE_CONE: r_res <= r_hok && (r_sq <= 62'(r_rr))
                            && (r_ct >= $signed(56'({aly, 16'd0})));
                        SHAPE_STRIP: r_res <= r_hok && !r_lx[LB-1]
                            && (r_lx <= LB'(r_cfg.slen))
                            && (31'(aly) * 2 <= 31'(r_cfg.swid));
                        SHAPE_SQUARE: r_res <= r_hok
                            && (31'(alx) * 2 <= 31'(r_cfg.swid))
                            && (31'(aly) * 2 <= 31'(r_cfg.swid));
                        SHAPE_POLY: begin
                            r_res    <= 1'b0;
                            r_inside <= 1'b0;
                            r_n      <= nsat;
                            r_cnt    <= 7'd0;
                            r_first  <= 1'b1;
                            if (r_hok && nsat != 7'd0) r_st <= S_RD;
                        end
                        default: r_res <= 1'b0;
                    endcase
                end
                S_RD: begin
                    // address issued this cycle; data next cycle
                    r_st <= S_E1;
                end
                S_E1: begin
                    r_bx <= 17'($signed(vm_rdata[15:0]));
                    r_by <= 17'($signed(vm_rdata[31:16]));
                    if (r_first) begin
                        r_ax    <= 17'($signed(vm_rdata[15:0]));
                        r_ay    <= 17'($signed(vm_rdata[31:16]));
                        r_first <= 1'b0;
                        r_cnt   <= 7'd1;
                        r_st    <= S_RD;
                    end else begin
                        r_st <= S_E2;
                    end
                end
                S_E2: begin
                    r_m0 <= 62'(ebx) * 62'(pay);
                    r_m1 <= 62'(eby) * 62'(pax);
                    r_m2 <= 62'(pax) * 62'(pbx);
                    r_m3 <= 62'(pay) * 62'(pby);
                    r_m4 <= 62'(pax) * 62'(eby);
                    r_m5 <= 62'(ebx) * 62'(pay);
                    r_st <= S_E3;
                end
                S_E3: begin
                    if (on_e) begin
                        r_res <= 1'b1;
                        r_st  <= S_OUT;
                    end else begin
                        if (straddle && crs) r_inside <= !r_inside;
                        r_ax <= r_bx;
                        r_ay <= r_by;
                        if (r_cnt == r_n) begin
                            r_res <= r_inside ^ (straddle && crs);
                            r_st  <= S_OUT;
                        end else begin
                            r_cnt <= r_cnt + 7'd1;
                            r_st  <= S_RD;
                        end
                    end
                end
                S_OUT: begin
                    r_ovld <= 1'b1;
                    r_st   <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
    a_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |=> r_ovld) else $error("result lost");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_E3) |-> (r_cnt <= r_n)) else $error("edge count overrun");
endmodule
